### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define EDF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define EDF_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define EDF_ASSERT(lbl, prop)
`define EDF_ASSERT_NEVER(lbl, cond)
`endif

`endif

### rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared constants and types of the EDF tick scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int MAX_TASKS = 8;
	localparam int TIME_BITS = 32;

	localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int PER_W  = 16;
	localparam int EXEC_W = 16;
	localparam int RUN_W  = 16;
	localparam int SLOT_W = 3;
	localparam int CFG_W  = 4;
	localparam int TOUT_W = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} edf_state_t;

	typedef struct packed {
		logic [PER_W-1:0]     period;
		logic [EXEC_W-1:0]    exec;
		logic [TIME_BITS-1:0] deadline;
		logic [RUN_W-1:0]     count;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		slot_rec_t         wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

### rtl/edf_ram.sv
// ----------------------------------------------------------------------------
// edf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module edf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/edf_ctrl.sv
// ----------------------------------------------------------------------------
// edf_ctrl
// Slot load, per-tick scan of the slot RAM, and job update write-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edf_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [edf_pkg::SLOT_W-1:0]          task_slot,
	input  logic [edf_pkg::PER_W-1:0]           period_in,
	input  logic [edf_pkg::EXEC_W-1:0]          exec_in,
	input  logic [edf_pkg::CFG_W-1:0]           active_tasks,
	output edf_pkg::ram_req_t                   ram_req,
	input  logic [edf_pkg::REC_W-1:0]           ram_rdata,
	output logic                                valid,
	output logic                                idle,
	output logic [edf_pkg::SLOT_W-1:0]          task_index,
	output logic                                job_done,
	output logic [edf_pkg::TOUT_W-1:0]          tick_time
);

	localparam int TB = edf_pkg::TIME_BITS;
	localparam int AW = edf_pkg::ADDR_W;
	localparam int CW = edf_pkg::CNT_W;

	edf_pkg::edf_state_t state_q, state_d;

	logic [CW-1:0]      n_q;
	logic [CW-1:0]      rd_idx_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               found_q;
	logic [TB-1:0]      best_d_q;
	logic [AW-1:0]      best_idx_q;
	edf_pkg::slot_rec_t best_rec_q;
	logic [TB-1:0]      time_now_q;

	logic               accept;
	logic               issue;
	logic [CW-1:0]      n_sat;
	edf_pkg::slot_rec_t rec;
	logic [TB-1:0]      dl_gap;
	logic               rel;
	logic               better;
	logic [edf_pkg::RUN_W-1:0] cnt_inc;
	logic               fin;
	edf_pkg::slot_rec_t wb_rec;
	edf_pkg::slot_rec_t ld_rec;

	assign accept = start && !busy;
	assign issue  = (rd_idx_q < n_q);

	always_comb begin
		if (int'(active_tasks) > edf_pkg::MAX_TASKS) begin
			n_sat = CW'(edf_pkg::MAX_TASKS);
		end else begin
			n_sat = CW'(active_tasks);
		end
	end

	assign rec    = edf_pkg::slot_rec_t'(ram_rdata);
	assign dl_gap = rec.deadline - time_now_q;
	assign rel    = dl_gap[TB-1] || (dl_gap <= TB'(rec.period));
	assign better = !found_q || ($signed(dl_gap) < $signed(best_d_q));

	assign cnt_inc = best_rec_q.count + edf_pkg::RUN_W'(1);
	assign fin     = (cnt_inc >= best_rec_q.exec);

	always_comb begin
		wb_rec          = best_rec_q;
		wb_rec.count    = fin ? '0 : cnt_inc;
		wb_rec.deadline = fin ? best_rec_q.deadline + TB'(best_rec_q.period)
			: best_rec_q.deadline;
		ld_rec.period   = period_in;
		ld_rec.exec     = exec_in;
		ld_rec.deadline = TB'(period_in);
		ld_rec.count    = '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			edf_pkg::ST_IDLE: begin
				if (accept && cmd == edf_pkg::CMD_TICK) begin
					state_d = edf_pkg::ST_SCAN;
				end
			end
			edf_pkg::ST_SCAN: begin
				if (!issue) begin
					state_d = edf_pkg::ST_DONE;
				end
			end
			edf_pkg::ST_DONE: begin
				state_d = edf_pkg::ST_IDLE;
			end
			default: begin
				state_d = edf_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ram_req       = '0;
		ram_req.raddr = rd_idx_q[AW-1:0];
		busy          = 1'b1;
		valid         = 1'b0;
		unique case (state_q)
			edf_pkg::ST_IDLE: begin
				busy          = 1'b0;
				ram_req.we    = start && cmd == edf_pkg::CMD_LOAD
					&& int'(task_slot) < edf_pkg::MAX_TASKS;
				ram_req.waddr = AW'(task_slot);
				ram_req.wdata = ld_rec;
			end
			edf_pkg::ST_SCAN: begin
				ram_req.re = issue;
			end
			edf_pkg::ST_DONE: begin
				valid         = 1'b1;
				ram_req.we    = found_q;
				ram_req.waddr = best_idx_q;
				ram_req.wdata = wb_rec;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign idle       = !found_q;
	assign task_index = found_q ? edf_pkg::SLOT_W'(best_idx_q) : '0;
	assign job_done   = found_q && fin;
	assign tick_time  = edf_pkg::TOUT_W'(time_now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= edf_pkg::ST_IDLE;
			n_q        <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			time_now_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == edf_pkg::ST_SCAN) && issue;
			if (state_q == edf_pkg::ST_IDLE && accept && cmd == edf_pkg::CMD_TICK) begin
				n_q      <= n_sat;
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else if (state_q == edf_pkg::ST_SCAN) begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (rd_vld_s1 && rel && better) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == edf_pkg::ST_DONE) begin
				time_now_q <= time_now_q + TB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[AW-1:0];
		if (state_q == edf_pkg::ST_SCAN && rd_vld_s1 && rel && better) begin
			best_d_q   <= dl_gap;
			best_idx_q <= rd_idx_s1;
			best_rec_q <= rec;
		end
	end

	`EDF_ASSERT(a_valid_single, valid |=> !valid)
	`EDF_ASSERT(a_time_step, valid |=> time_now_q == TB'($past(time_now_q) + TB'(1)))
	`EDF_ASSERT_NEVER(a_no_wr_in_scan, ram_req.we && state_q == edf_pkg::ST_SCAN)
	`EDF_ASSERT(a_best_in_range, valid && found_q |-> int'(best_idx_q) < int'(n_q))

endmodule

### rtl/edf_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler_top: one load per cycle while not busy; a tick holds busy while
// it scans the active slots (up to 8), one slot RAM read per cycle, and writes back;
// result strobed in the last busy cycle; a new command is taken once busy drops.
// Results cannot be stalled. Reset clears time, active_tasks and control state;
// ----------------------------------------------------------------------------
module edf_tick_scheduler_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [edf_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [edf_pkg::SLOT_W-1:0] task_slot,
	input  logic [edf_pkg::PER_W-1:0]  period_in,
	input  logic [edf_pkg::EXEC_W-1:0] exec_in,
	output logic                       valid,
	output logic                       idle,
	output logic [edf_pkg::SLOT_W-1:0] task_index,
	output logic                       job_done,
	output logic [edf_pkg::TOUT_W-1:0] tick_time
);

	// slot RAM contents stay undefined until loaded
	logic [edf_pkg::CFG_W-1:0] active_q;
	edf_pkg::ram_req_t         ram_req;
	logic [edf_pkg::REC_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	edf_ram #(
		.WIDTH (edf_pkg::REC_W),
		.DEPTH (edf_pkg::MAX_TASKS),
		.AW    (edf_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	edf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.task_slot    (task_slot),
		.period_in    (period_in),
		.exec_in      (exec_in),
		.active_tasks (active_q),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.valid        (valid),
		.idle         (idle),
		.task_index   (task_index),
		.job_done     (job_done),
		.tick_time    (tick_time)
	);

endmodule
